/* design/tce_pkg.sv */
// ----------------------------------------------------------------------------
// tce_pkg
// Shared opcodes, jump conditions and controller/datapath command types.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int unsigned NUM_REGS = 9;

    typedef enum logic [3:0] {
        OP_MOV    = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV    = 4'd4,
        OP_AND    = 4'd5,
        OP_OR     = 4'd6,
        OP_NOT    = 4'd7,
        OP_CMP    = 4'd8,
        OP_JMP    = 4'd9,
        OP_IN     = 4'd10,
        OP_OUT    = 4'd11,
        OP_LOCK   = 4'd12,
        OP_UNLOCK = 4'd13,
        OP_SLEEP  = 4'd14,
        OP_NONE   = 4'd15
    } op_t;

    localparam logic [3:0] COND_ALWAYS  = 4'd0;
    localparam logic [3:0] COND_EQUAL   = 4'd1;
    localparam logic [3:0] COND_GREATER = 4'd2;
    localparam logic [3:0] COND_LESS    = 4'd3;

    localparam logic [1:0] FLAG_EQ = 2'b00;
    localparam logic [1:0] FLAG_GT = 2'b01;
    localparam logic [1:0] FLAG_LT = 2'b11;

    localparam logic [3:0] SR_LOAD_MIN = 4'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the instruction
        logic clr_step;  // memory clear: write one byte
        logic rd_hi;     // issue read of high byte
        logic rd_lo;     // issue read of low byte
        logic iter_init; // start multiply/divide
        logic iter_step; // one multiply/divide step
        logic wr_hi;     // write high byte of store data
        logic wr_lo;     // write low byte of store data
        logic commit;    // update state and result register
    } tce_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic needs_mem;
        logic is_iter;
        logic needs_store;
        logic iter_done;
    } tce_stat_t;

endpackage

/* design/tce_if.sv */
// ----------------------------------------------------------------------------
// tce_in_if / tce_out_if
// Valid/ready channels for instructions and results.
// ----------------------------------------------------------------------------
interface tce_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [3:0]  dst_sel;
    logic [3:0]  src_sel;
    logic signed [15:0] imm;
    logic signed [15:0] user_value;

    modport source (output valid, func, dst_sel, src_sel, imm, user_value,
                    input ready);
    modport sink (input valid, func, dst_sel, src_sel, imm, user_value,
                  output ready);
endinterface

interface tce_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_ip;
    logic signed [1:0]  compare_flag;
    logic signed [15:0] dest_value;
    logic        print_valid;
    logic signed [15:0] print_value;
    logic        divide_by_zero;

    modport source (output valid, next_ip, compare_flag, dest_value, print_valid,
                    print_value, divide_by_zero, input ready);
    modport sink (input valid, next_ip, compare_flag, dest_value, print_valid,
                  print_value, divide_by_zero, output ready);
endinterface

/* design/tce_ctrl.sv */
// ----------------------------------------------------------------------------
// tce_ctrl
// Sequencer: memory clear after reset, operand fetch, iterate, store, commit.
// ----------------------------------------------------------------------------
module tce_ctrl
    import tce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      res_busy,
    input  tce_stat_t stat,
    output tce_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RDHI  = 9'b000000100,
        S_RDLO  = 9'b000001000,
        S_WAIT  = 9'b000010000,
        S_INIT  = 9'b000100000,
        S_ITER  = 9'b001000000,
        S_STORE = 9'b010000000,
        S_COMM  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RDHI;
                end
            end
            S_RDHI:
            begin
                if (stat.needs_mem)
                begin
                    cmd.rd_hi  = 1'b1;
                    state_next = S_RDLO;
                end
                else if (stat.is_iter)
                begin
                    state_next = S_INIT;
                end
                else if (stat.needs_store)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_COMM;
                end
            end
            S_RDLO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.is_iter)
                begin
                    state_next = S_INIT;
                end
                else if (stat.needs_store)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_COMM;
                end
            end
            S_INIT:
            begin
                cmd.iter_init = 1'b1;
                state_next    = S_ITER;
            end
            S_ITER:
            begin
                cmd.iter_step = 1'b1;
                if (stat.iter_done)
                begin
                    state_next = S_COMM;
                end
            end
            S_STORE:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = S_COMM;
            end
            S_COMM:
            begin
                if (!res_busy)
                begin
                    cmd.commit = 1'b1;
                    cmd.wr_lo  = stat.needs_store;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* design/tce_dp.sv */
// ----------------------------------------------------------------------------
// tce_dp
// Datapath: register file, ip, flag, byte memory, shared mul/div unit.
// ----------------------------------------------------------------------------
module tce_dp
    import tce_pkg::*;
#(
    parameter int unsigned MEM_BYTES = 4096,
    parameter int unsigned IP_STEP   = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  tce_cmd_t    cmd,
    output tce_stat_t   stat,
    input  logic [3:0]  func,
    input  logic [3:0]  dst_sel,
    input  logic [3:0]  src_sel,
    input  logic [15:0] imm,
    input  logic [15:0] user_value,
    output logic [15:0] r_next_ip,
    output logic [1:0]  r_flag,
    output logic [15:0] r_dest,
    output logic        r_print_valid,
    output logic [15:0] r_print_value,
    output logic        r_dz
);

    localparam int unsigned AW = $clog2(MEM_BYTES);

    logic [7:0]  mem [MEM_BYTES];
    logic [15:0] rf_reg [NUM_REGS];
    logic [15:0] ip_reg;
    logic [1:0]  flag_reg;
    logic [AW-1:0] clr_reg;

    logic [3:0]  func_reg, fr_reg, sr_reg;
    logic [15:0] imm_reg, uv_reg;
    logic [15:0] dst_reg, sval_reg, fval_reg;
    logic [7:0]  rd_reg;
    logic [7:0]  hi_reg;
    logic [15:0] opnd_mem_reg;
    logic        hi_en_reg;

    // multiply/divide
    logic [15:0] acc_reg;
    logic [15:0] mcand_reg;
    logic [15:0] q_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic        neg_q_reg;
    logic [4:0]  cnt_reg;

    logic        fr_ok;
    logic [15:0] opnd;
    logic        is_mov_store, is_not_mem;
    logic [15:0] addr_base;
    logic [AW-1:0] rd_a, wr_a;
    logic        wr_en;
    logic [7:0]  wr_d;
    logic [15:0] store_val;

    assign fr_ok = fr_reg < 4'(NUM_REGS);

    assign is_mov_store = (func_reg == OP_MOV) && sr_reg != 4'd0 && sr_reg < SR_LOAD_MIN;
    assign is_not_mem   = (func_reg == OP_NOT) && sr_reg != 4'd0;

    assign opnd = (sr_reg == 4'd0) ? imm_reg : opnd_mem_reg;

    always_comb
    begin
        stat.clr_done    = clr_reg == AW'(MEM_BYTES - 1);
        stat.needs_mem   = sr_reg != 4'd0 && !is_mov_store &&
                           (func_reg == OP_MOV || func_reg == OP_ADD ||
                            func_reg == OP_SUB || func_reg == OP_MUL ||
                            func_reg == OP_DIV || func_reg == OP_AND ||
                            func_reg == OP_OR  || func_reg == OP_NOT ||
                            func_reg == OP_CMP);
        stat.is_iter     = (func_reg == OP_MUL || func_reg == OP_DIV);
        stat.needs_store = is_mov_store || is_not_mem;
        stat.iter_done   = cnt_reg == 5'd15;
    end

    // byte address: store to reg fr address, otherwise reg sr address
    assign addr_base = is_mov_store ? fval_reg : sval_reg;
    assign store_val = is_mov_store ? sval_reg : {15'd0, opnd_mem_reg == 16'd0};

    always_comb
    begin
        rd_a  = addr_base[AW-1:0];
        if (cmd.rd_lo)
        begin
            rd_a = addr_base[AW-1:0] + AW'(1);
        end
        wr_en = 1'b0;
        wr_a  = addr_base[AW-1:0];
        wr_d  = store_val[15:8];
        if (cmd.clr_step)
        begin
            wr_en = 1'b1;
            wr_a  = clr_reg;
            wr_d  = 8'd0;
        end
        else if (cmd.wr_hi)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr_lo)
        begin
            wr_en = 1'b1;
            wr_a  = addr_base[AW-1:0] + AW'(1);
            wr_d  = store_val[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_a] <= wr_d;
        end
        rd_reg <= mem[rd_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            fr_reg   <= dst_sel;
            sr_reg   <= src_sel;
            imm_reg  <= imm;
            uv_reg   <= user_value;
            dst_reg  <= (dst_sel < 4'(NUM_REGS)) ? rf_reg[dst_sel] : 16'd0;
            fval_reg <= (dst_sel < 4'(NUM_REGS)) ? rf_reg[dst_sel] : 16'd0;
            sval_reg <= (src_sel < 4'(NUM_REGS)) ? rf_reg[src_sel] : 16'd0;
        end
        if (cmd.rd_lo)
        begin
            hi_reg <= rd_reg;
        end
        if (cmd.load)
        begin
            opnd_mem_reg <= 16'd0;
        end
        else if (!cmd.rd_lo && !cmd.rd_hi && hi_en_reg)
        begin
            opnd_mem_reg <= {hi_reg, rd_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_en_reg <= 1'b0;
        end
        else
        begin
            hi_en_reg <= cmd.rd_lo;
        end
    end

    // shared multiply / divide, one bit a cycle
    logic [15:0] ad, ao;
    logic [16:0] rem_sh;
    assign ad = dst_reg[15] ? (16'd0 - dst_reg) : dst_reg;
    assign ao = opnd[15] ? (16'd0 - opnd) : opnd;
    assign rem_sh = {rem_reg[15:0], q_reg[15]};

    always_ff @(posedge clk)
    begin
        if (cmd.iter_init)
        begin
            acc_reg   <= 16'd0;
            mcand_reg <= dst_reg;
            q_reg     <= ad;
            rem_reg   <= 17'd0;
            dvs_reg   <= ao;
            neg_q_reg <= dst_reg[15] ^ opnd[15];
            cnt_reg   <= 5'd0;
        end
        else if (cmd.iter_step)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (opnd[cnt_reg[3:0]])
            begin
                acc_reg <= acc_reg + (mcand_reg << cnt_reg[3:0]);
            end
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
    end

    // commit
    logic [15:0] res;
    logic        wr_rf, dz;
    logic [15:0] ip_new;
    logic [1:0]  flag_new;
    logic        take;
    logic signed [15:0] sd, so;
    assign sd = dst_reg;
    assign so = opnd;

    always_comb
    begin
        res      = 16'd0;
        wr_rf    = 1'b0;
        dz       = 1'b0;
        flag_new = flag_reg;
        ip_new   = ip_reg + 16'(IP_STEP);
        take     = 1'b0;
        unique case (func_reg)
            OP_MOV:
            begin
                wr_rf = !is_mov_store;
                res   = (sr_reg == 4'd0) ? imm_reg : opnd_mem_reg;
            end
            OP_ADD: begin wr_rf = 1'b1; res = dst_reg + opnd; end
            OP_SUB: begin wr_rf = 1'b1; res = dst_reg - opnd; end
            OP_MUL: begin wr_rf = 1'b1; res = acc_reg; end
            OP_DIV:
            begin
                dz    = opnd == 16'd0;
                wr_rf = !dz;
                res   = neg_q_reg ? (16'd0 - q_reg) : q_reg;
            end
            OP_AND:
            begin
                wr_rf = 1'b1;
                res   = {15'd0, dst_reg != 16'd0 && opnd != 16'd0};
            end
            OP_OR:
            begin
                wr_rf = 1'b1;
                res   = {15'd0, dst_reg != 16'd0 || opnd != 16'd0};
            end
            OP_NOT:
            begin
                wr_rf = sr_reg == 4'd0;
                res   = {15'd0, dst_reg == 16'd0};
            end
            OP_CMP:
            begin
                flag_new = (sd == so) ? FLAG_EQ : ((sd > so) ? FLAG_GT : FLAG_LT);
            end
            OP_JMP:
            begin
                take = sr_reg == COND_ALWAYS ||
                       (sr_reg == COND_EQUAL && flag_reg == FLAG_EQ) ||
                       (sr_reg == COND_GREATER && flag_reg == FLAG_GT) ||
                       (sr_reg == COND_LESS && flag_reg == FLAG_LT);
                if (take)
                begin
                    ip_new = ip_reg + imm_reg;
                end
                else if (sr_reg > COND_LESS)
                begin
                    ip_new = ip_reg;
                end
            end
            OP_IN: begin wr_rf = 1'b1; res = uv_reg; end
            OP_OUT, OP_LOCK, OP_UNLOCK, OP_SLEEP:
            begin
            end
            default:
            begin
                ip_new = ip_reg;
            end
        endcase
        wr_rf = wr_rf && fr_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= 16'd0;
            end
            ip_reg   <= 16'd0;
            flag_reg <= FLAG_EQ;
        end
        else if (cmd.commit)
        begin
            if (wr_rf)
            begin
                rf_reg[fr_reg] <= res;
            end
            ip_reg   <= ip_new;
            flag_reg <= flag_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            r_next_ip     <= ip_new;
            r_flag        <= flag_new;
            r_dest        <= !fr_ok ? 16'd0 : (wr_rf ? res : dst_reg);
            r_print_valid <= func_reg == OP_OUT;
            r_print_value <= (func_reg == OP_OUT) ? dst_reg : 16'd0;
            r_dz          <= (func_reg == OP_DIV) && dz;
        end
    end

endmodule

/* design/toy_cpu_execute_unit_top.sv */
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_top
// Execute unit of a 16-bit toy processor: one instruction in, one result out.
//
//   channel   dir  payload
//   in_ch     in   func, dst_sel, src_sel, imm, user_value
//   out_ch    out  next_ip, compare_flag, dest_value, print_valid,
//                  print_value, divide_by_zero
//
// Sequence: load, then for a memory operand a read of the high and low byte,
// then multiply/divide on the 16-step shared shift unit, or a write of the
// high byte for a register store or a not on memory, then commit, which also
// writes the low byte of a store; simple ops go from load to commit. Reset:
// a clearing pass zeroes the whole byte memory; no beat is taken meanwhile.
// Stalls: a result waits in the output register while the next beat is
// taken and worked on; its commit holds until the result is taken.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit_top
    import tce_pkg::*;
#(
    parameter int unsigned MEM_BYTES = 4096,
    parameter int unsigned IP_STEP   = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    tce_in_if.sink    in_ch,
    tce_out_if.source out_ch
);

    tce_cmd_t  cmd;
    tce_stat_t stat;
    logic      vld_reg;
    logic [15:0] r_ip, r_dest, r_pv;
    logic [1:0]  r_flag;
    logic        r_pvalid, r_dz;

    tce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .res_busy (vld_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    tce_dp #(
        .MEM_BYTES (MEM_BYTES),
        .IP_STEP   (IP_STEP)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (in_ch.func),
        .dst_sel       (in_ch.dst_sel),
        .src_sel       (in_ch.src_sel),
        .imm           (in_ch.imm),
        .user_value    (in_ch.user_value),
        .r_next_ip     (r_ip),
        .r_flag        (r_flag),
        .r_dest        (r_dest),
        .r_print_valid (r_pvalid),
        .r_print_value (r_pv),
        .r_dz          (r_dz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            vld_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    assign out_ch.valid          = vld_reg;
    assign out_ch.next_ip        = r_ip;
    assign out_ch.compare_flag   = r_flag;
    assign out_ch.dest_value     = r_dest;
    assign out_ch.print_valid    = r_pvalid;
    assign out_ch.print_value    = r_pv;
    assign out_ch.divide_by_zero = r_dz;

endmodule

/* design/tce_checker.sv */
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks on the execute unit.
// ----------------------------------------------------------------------------
module tce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] next_ip,
    input logic        print_valid,
    input logic        divide_by_zero
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_ip))
        else $error("result dropped while stalled");

    a_no_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken before result");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(print_valid && divide_by_zero))
        else $error("print and divide error together");

    a_no_result_unasked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid || $past(out_valid))
        else $error("result appeared at accept");

endmodule

bind toy_cpu_execute_unit_top tce_checker u_tce_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .next_ip        (out_ch.next_ip),
    .print_valid    (out_ch.print_valid),
    .divide_by_zero (out_ch.divide_by_zero)
);

/* dv/tb_toy_cpu_execute_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toy_cpu_execute_unit_top
// Self-checking bench for the toy processor execute unit. A built-in model of
// the register file, instruction pointer, compare flag and byte memory
// predicts every result beat. Directed instructions cover the extremes of
// the fields and the special cases, then random instruction streams run under
// three idling profiles on the instruction and result channels.
// ----------------------------------------------------------------------------
module tb_toy_cpu_execute_unit_top;
    import tce_pkg::*;

    localparam int unsigned MEM_BYTES = 4096;
    localparam int unsigned IP_STEP   = 4;
    localparam int unsigned AW        = $clog2(MEM_BYTES);

    typedef struct packed {
        op_t         func;
        logic [3:0]  dst_sel;
        logic [3:0]  src_sel;
        logic [15:0] imm;
        logic [15:0] user_value;
    } instr_t;

    typedef struct packed {
        logic [15:0] next_ip;
        logic [1:0]  compare_flag;
        logic [15:0] dest_value;
        logic        print_valid;
        logic [15:0] print_value;
        logic        divide_by_zero;
    } outcome_t;

    logic clk;
    logic rst_n;

    tce_in_if  in_ch ();
    tce_out_if out_ch ();

    toy_cpu_execute_unit_top #(.MEM_BYTES(MEM_BYTES), .IP_STEP(IP_STEP)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    logic [15:0] regs [NUM_REGS];
    logic [15:0] ip_model;
    logic [1:0]  flag_model;
    logic [7:0]  mem_model [MEM_BYTES];

    outcome_t pending_outcomes [$];
    int       error_count;
    int       send_idle_pct;
    int       recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [15:0] reg_read(logic [3:0] idx);
        return (idx < NUM_REGS) ? regs[idx] : 16'd0;
    endfunction

    function automatic logic [15:0] mem_read(logic [15:0] addr);
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        a = AW'(addr % MEM_BYTES);
        b = AW'((a + 1) % MEM_BYTES);
        return {mem_model[a], mem_model[b]};
    endfunction

    task automatic mem_write(logic [15:0] addr, logic [15:0] val);
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        a = AW'(addr % MEM_BYTES);
        b = AW'((a + 1) % MEM_BYTES);
        mem_model[a] = val[15:8];
        mem_model[b] = val[7:0];
    endtask

    task automatic reg_write(logic [3:0] idx, logic [15:0] val);
        if (idx < NUM_REGS)
            regs[idx] = val;
    endtask

    task automatic execute_instr(input instr_t t, output outcome_t r);
        int  dst;
        int  opnd;
        bit  adv;
        bit  take;
        logic [15:0] nip;
        dst  = $signed(reg_read(t.dst_sel));
        opnd = (t.src_sel == 0) ? $signed(t.imm)
                                : $signed(mem_read(reg_read(t.src_sel)));
        adv  = 1'b1;
        nip  = ip_model;
        r    = '0;
        case (t.func)
            OP_MOV:
                if (t.src_sel == 0)
                    reg_write(t.dst_sel, t.imm);
                else if (t.src_sel >= SR_LOAD_MIN)
                    reg_write(t.dst_sel, mem_read(reg_read(t.src_sel)));
                else
                    mem_write(reg_read(t.dst_sel), reg_read(t.src_sel));
            OP_ADD: reg_write(t.dst_sel, 16'(dst + opnd));
            OP_SUB: reg_write(t.dst_sel, 16'(dst - opnd));
            OP_MUL: reg_write(t.dst_sel, 16'(dst * opnd));
            OP_DIV:
                if (opnd == 0)
                    r.divide_by_zero = 1'b1;
                else
                    reg_write(t.dst_sel, 16'(dst / opnd));
            OP_AND: reg_write(t.dst_sel, (dst != 0 && opnd != 0) ? 16'd1 : 16'd0);
            OP_OR:  reg_write(t.dst_sel, (dst != 0 || opnd != 0) ? 16'd1 : 16'd0);
            OP_NOT:
                if (t.src_sel == 0)
                    reg_write(t.dst_sel, (dst == 0) ? 16'd1 : 16'd0);
                else
                    mem_write(reg_read(t.src_sel), (opnd == 0) ? 16'd1 : 16'd0);
            OP_CMP:
                flag_model = (dst == opnd) ? FLAG_EQ : ((dst > opnd) ? FLAG_GT : FLAG_LT);
            OP_JMP:
            begin
                adv  = 1'b0;
                take = (t.src_sel == COND_ALWAYS)
                    || (t.src_sel == COND_EQUAL   && flag_model == FLAG_EQ)
                    || (t.src_sel == COND_GREATER && flag_model == FLAG_GT)
                    || (t.src_sel == COND_LESS    && flag_model == FLAG_LT);
                if (take)
                    nip = ip_model + t.imm;
                else if (t.src_sel <= COND_LESS)
                    nip = ip_model + 16'(IP_STEP);
            end
            OP_IN: reg_write(t.dst_sel, t.user_value);
            OP_OUT:
            begin
                r.print_valid = 1'b1;
                r.print_value = reg_read(t.dst_sel);
            end
            OP_LOCK, OP_UNLOCK, OP_SLEEP: ;
            default: adv = 1'b0;
        endcase
        if (adv)
            nip = nip + 16'(IP_STEP);
        ip_model       = nip;
        r.next_ip      = ip_model;
        r.compare_flag = flag_model;
        r.dest_value   = reg_read(t.dst_sel);
    endtask

    task automatic send_instr(input instr_t t);
        outcome_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= t.func;
        in_ch.dst_sel    <= t.dst_sel;
        in_ch.src_sel    <= t.src_sel;
        in_ch.imm        <= t.imm;
        in_ch.user_value <= t.user_value;
        do
            @(negedge clk);
        while (!in_ch.ready);
        execute_instr(t, r);
        pending_outcomes.push_back(r);
        @(posedge clk);
    endtask

    function automatic instr_t make_instr(op_t f, logic [3:0] fr, logic [3:0] sr,
                                          logic [15:0] imm, logic [15:0] uv);
        instr_t t;
        t.func = f; t.dst_sel = fr; t.src_sel = sr; t.imm = imm; t.user_value = uv;
        return t;
    endfunction

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(negedge clk)
    begin
        outcome_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result beat with no instruction outstanding");
                error_count++;
            end
            else
            begin
                exp_r = pending_outcomes.pop_front();
                if (out_ch.next_ip !== exp_r.next_ip)
                begin
                    $error("next_ip exp %h got %h", exp_r.next_ip, out_ch.next_ip);
                    error_count++;
                end
                if (out_ch.compare_flag !== exp_r.compare_flag)
                begin
                    $error("compare_flag exp %h got %h", exp_r.compare_flag,
                           out_ch.compare_flag);
                    error_count++;
                end
                if (out_ch.dest_value !== exp_r.dest_value)
                begin
                    $error("dest_value exp %h got %h", exp_r.dest_value, out_ch.dest_value);
                    error_count++;
                end
                if (out_ch.print_valid !== exp_r.print_valid)
                begin
                    $error("print_valid exp %b got %b", exp_r.print_valid,
                           out_ch.print_valid);
                    error_count++;
                end
                if (out_ch.print_value !== exp_r.print_value)
                begin
                    $error("print_value exp %h got %h", exp_r.print_value,
                           out_ch.print_value);
                    error_count++;
                end
                if (out_ch.divide_by_zero !== exp_r.divide_by_zero)
                begin
                    $error("divide_by_zero exp %b got %b", exp_r.divide_by_zero,
                           out_ch.divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed_ops();
        send_instr(make_instr(OP_MOV, 4'd1, 4'd0, 16'h7FFF, 16'h0000));
        send_instr(make_instr(OP_MOV, 4'd5, 4'd0, 16'h0FFF, 16'hFFFF));
        send_instr(make_instr(OP_MOV, 4'd5, 4'd1, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_MOV, 4'd2, 4'd5, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_ADD, 4'd1, 4'd0, 16'h0001, 16'h0000));
        send_instr(make_instr(OP_SUB, 4'd2, 4'd5, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_MUL, 4'd1, 4'd0, 16'hFFFF, 16'h0000));
        send_instr(make_instr(OP_IN,  4'd3, 4'd0, 16'h0000, 16'h8000));
        send_instr(make_instr(OP_DIV, 4'd3, 4'd0, 16'hFFFF, 16'h0000));
        send_instr(make_instr(OP_DIV, 4'd3, 4'd0, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_DIV, 4'd2, 4'd0, 16'hFFFD, 16'h0000));
        send_instr(make_instr(OP_AND, 4'd4, 4'd0, 16'h8000, 16'h0000));
        send_instr(make_instr(OP_OR,  4'd4, 4'd0, 16'h8000, 16'h0000));
        send_instr(make_instr(OP_NOT, 4'd4, 4'd0, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_NOT, 4'd1, 4'd5, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_OUT, 4'd2, 4'd0, 16'h0000, 16'h0000));
    endtask

    task automatic test_compare_and_jump();
        send_instr(make_instr(OP_CMP,  4'd3, 4'd0, 16'h7FFF, 16'h0000));
        send_instr(make_instr(OP_JMP,  4'd0, COND_LESS, 16'h8000, 16'h0000));
        send_instr(make_instr(OP_JMP,  4'd0, COND_GREATER, 16'h0010, 16'h0000));
        send_instr(make_instr(OP_JMP,  4'd0, 4'd7, 16'h0010, 16'h0000));
        send_instr(make_instr(OP_CMP,  4'd4, 4'd0, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_JMP,  4'd0, COND_EQUAL, 16'hFFF8, 16'h0000));
        send_instr(make_instr(OP_JMP,  4'd0, COND_ALWAYS, 16'h7FFF, 16'h0000));
        send_instr(make_instr(OP_LOCK, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_UNLOCK, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF));
        send_instr(make_instr(OP_SLEEP, 4'd8, 4'd8, 16'h0000, 16'h0000));
        send_instr(make_instr(OP_NONE, 4'd1, 4'd0, 16'h1234, 16'h0000));
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(8)) - 4);
            3: return 16'($urandom_range(MEM_BYTES - 1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random_stream(input int count);
        instr_t t;
        for (int i = 0; i < count; i++)
        begin
            t.imm        = rand_value();
            t.user_value = rand_value();
            t.dst_sel    = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                                      : 4'($urandom_range(8));
            case ($urandom_range(9))
                0, 1: t.src_sel = 4'd0;
                2, 3: t.src_sel = 4'($urandom_range(8, 5));
                4, 5: t.src_sel = 4'($urandom_range(4, 1));
                6:    t.src_sel = 4'($urandom_range(15, 9));
                default: t.src_sel = 4'($urandom_range(8));
            endcase
            if ($urandom_range(39) == 0)
                t.func = OP_NONE;
            else if ($urandom_range(3) == 0)
                t.func = OP_MOV;
            else
                t.func = op_t'(4'($urandom_range(14)));
            send_instr(t);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = OP_MOV;
        in_ch.dst_sel    = '0;
        in_ch.src_sel    = '0;
        in_ch.imm        = '0;
        in_ch.user_value = '0;
        out_ch.ready     = 1'b0;
        error_count      = 0;
        send_idle_pct    = 34;
        recv_idle_pct    = 80;
        ip_model         = '0;
        flag_model       = FLAG_EQ;
        foreach (regs[i])
            regs[i] = '0;
        foreach (mem_model[i])
            mem_model[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_compare_and_jump();
        test_random_stream(560);
        send_idle_pct = 80;
        recv_idle_pct = 34;
        test_random_stream(560);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(560);

        in_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
